/* src/srsm_pkg.sv */
// Package: shared types for the sorted row set merge unit
`timescale 1ns / 1ps
package srsm_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CMP,
		ST_FLUSH
	} st_t;

	typedef enum logic {
		MODE_UNION = 1'b0,
		MODE_INTERSECT = 1'b1
	} mode_t;

	typedef enum logic {
		SIDE_LEFT = 1'b0,
		SIDE_RIGHT = 1'b1
	} side_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic rewind;
	} fifo_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		logic put;
		logic elem;
		logic last;
	} res_ctl_t;

endpackage

/* src/srsm_if.sv */
// Interfaces: input item channel and result channel
`timescale 1ns / 1ps
interface srsm_in_if #(
	parameter int OFFSET_BITS = 24
);
	logic                   valid;
	logic                   ready;
	logic                   side;
	logic                   has_element;
	logic [OFFSET_BITS-1:0] row_offset;
	logic                   side_last;

	modport source (output valid, side, has_element, row_offset, side_last, input ready);
	modport sink (input valid, side, has_element, row_offset, side_last, output ready);
endinterface

interface srsm_out_if #(
	parameter int OFFSET_BITS = 24
);
	logic                   valid;
	logic                   ready;
	logic                   out_valid;
	logic [OFFSET_BITS-1:0] out_offset;
	logic                   out_last;
	logic                   overflow_error;

	modport source (output valid, out_valid, out_offset, out_last, overflow_error, input ready);
	modport sink (input valid, out_valid, out_offset, out_last, overflow_error, output ready);
endinterface

/* src/srsm_fifo.sv */
// Side FIFO: circular buffer with registered head read
`timescale 1ns / 1ps
module srsm_fifo #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srsm_pkg::fifo_cmd_t   cmd,
	input  logic [WIDTH-1:0]      wr_data,
	output srsm_pkg::fifo_stat_t  stat,
	output logic [WIDTH-1:0]      rd_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] rd_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1))
			return '0;
		return p + PW'(1);
	endfunction

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign do_push    = cmd.push && !stat.full;
	assign do_pop     = cmd.pop && !stat.empty;
	assign rd_data    = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.rewind) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				tail_q <= wrap_inc(tail_q);
			if (do_pop)
				head_q <= wrap_inc(head_q);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem[tail_q] <= wr_data;
		rd_q <= mem[head_q];
	end

endmodule

/* src/srsm_ctrl.sv */
// Merge sequencer: one head compare per pass, result hold, end detection
`timescale 1ns / 1ps
module srsm_ctrl #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   side,
	input  logic                   has_element,
	input  logic                   side_last,
	input  logic                   merge_mode,
	output srsm_pkg::fifo_cmd_t    l_cmd,
	output srsm_pkg::fifo_cmd_t    r_cmd,
	input  srsm_pkg::fifo_stat_t   l_stat,
	input  srsm_pkg::fifo_stat_t   r_stat,
	input  logic [OFFSET_BITS-1:0] l_data,
	input  logic [OFFSET_BITS-1:0] r_data,
	input  logic                   slot_free,
	output srsm_pkg::res_ctl_t     res,
	output logic [OFFSET_BITS-1:0] res_offset,
	output logic                   overflow
);
	srsm_pkg::st_t    st_q, st_d;
	srsm_pkg::mode_t  mode_q;
	logic             l_end_q, r_end_q;
	logic             err_q;
	logic             held_vld_q;
	logic [OFFSET_BITS-1:0] held_off_q;

	logic             accept;
	logic             side_open;
	logic             is_union;
	logic             emit;
	logic [OFFSET_BITS-1:0] emit_off;
	logic             pop_l, pop_r;
	logic             cmp_stall;
	logic             complete;
	logic             flush_need;

	assign accept    = in_valid && in_ready;
	assign side_open = (side == srsm_pkg::SIDE_LEFT) ? !l_end_q : !r_end_q;
	assign is_union  = (mode_q == srsm_pkg::MODE_UNION);
	assign complete  = l_end_q && r_end_q && l_stat.empty && r_stat.empty;
	assign flush_need = complete || held_vld_q;
	assign overflow  = err_q;

	always_comb begin
		emit     = 1'b0;
		emit_off = l_data;
		pop_l    = 1'b0;
		pop_r    = 1'b0;
		if (!l_stat.empty && !r_stat.empty) begin
			if (l_data < r_data) begin
				emit  = is_union;
				pop_l = 1'b1;
			end else if (l_data > r_data) begin
				emit     = is_union;
				emit_off = r_data;
				pop_r    = 1'b1;
			end else begin
				emit  = 1'b1;
				pop_l = 1'b1;
				pop_r = 1'b1;
			end
		end else if (!l_stat.empty && r_end_q) begin
			emit  = is_union;
			pop_l = 1'b1;
		end else if (!r_stat.empty && l_end_q) begin
			emit     = is_union;
			emit_off = r_data;
			pop_r    = 1'b1;
		end
	end

	assign cmp_stall = emit && held_vld_q && !slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= srsm_pkg::ST_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d       = st_q;
		in_ready   = 1'b0;
		l_cmd      = '0;
		r_cmd      = '0;
		res        = '0;
		res_offset = held_off_q;
		unique case (st_q)
			srsm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				l_cmd.push = in_valid && has_element && !l_end_q &&
				             (side == srsm_pkg::SIDE_LEFT);
				r_cmd.push = in_valid && has_element && !r_end_q &&
				             (side == srsm_pkg::SIDE_RIGHT);
				if (in_valid)
					st_d = srsm_pkg::ST_FETCH;
			end
			srsm_pkg::ST_FETCH: begin
				st_d = srsm_pkg::ST_CMP;
			end
			srsm_pkg::ST_CMP: begin
				if (!pop_l && !pop_r) begin
					st_d = srsm_pkg::ST_FLUSH;
				end else if (!cmp_stall) begin
					l_cmd.pop = pop_l;
					r_cmd.pop = pop_r;
					res.put   = emit && held_vld_q;
					res.elem  = 1'b1;
					st_d      = srsm_pkg::ST_FETCH;
				end
			end
			srsm_pkg::ST_FLUSH: begin
				if (!flush_need || slot_free) begin
					res.put      = flush_need;
					res.elem     = held_vld_q;
					res.last     = complete;
					res_offset   = held_vld_q ? held_off_q : '0;
					l_cmd.rewind = complete;
					r_cmd.rewind = complete;
					st_d         = srsm_pkg::ST_IDLE;
				end
			end
			default: st_d = srsm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= srsm_pkg::MODE_UNION;
			l_end_q    <= 1'b0;
			r_end_q    <= 1'b0;
			err_q      <= 1'b0;
			held_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q <= srsm_pkg::mode_t'(merge_mode);
				if (side_open && has_element &&
				    (((side == srsm_pkg::SIDE_LEFT) && l_stat.full) ||
				     ((side == srsm_pkg::SIDE_RIGHT) && r_stat.full)))
					err_q <= 1'b1;
				if (side_open && side_last) begin
					if (side == srsm_pkg::SIDE_LEFT)
						l_end_q <= 1'b1;
					else
						r_end_q <= 1'b1;
				end
			end
			if (st_q == srsm_pkg::ST_CMP && (pop_l || pop_r) && !cmp_stall && emit)
				held_vld_q <= 1'b1;
			if (st_q == srsm_pkg::ST_FLUSH && (!flush_need || slot_free)) begin
				held_vld_q <= 1'b0;
				if (complete) begin
					l_end_q <= 1'b0;
					r_end_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == srsm_pkg::ST_CMP && emit && !cmp_stall)
			held_off_q <= emit_off;
	end

endmodule

/* src/sorted_row_set_merge_unit.sv */
// Top level: sorted row set merge unit (union / intersection of two lists)
//
//   channel  dir  handshake        beat contents
//   in_ch    in   valid / ready    side, has_element, row_offset, side_last
//   out_ch   out  valid / ready    out_valid, out_offset, out_last, overflow_error
//   cfg      in   cfg_we           cfg_wdata -> merge_mode (0 union, 1 intersection)
//
// An input beat passes through accept, fetch, final compare and flush, with a further
// fetch and compare after each popping head compare, as the FIFO head reads are registered
// (at most FIFO_DEPTH + 1 popping compares per beat).
// Results leave through a one-beat output register; a result waits in a hold register
// until the next emitted result or the flush, so the last beat of a merge can carry out_last.
// A stalled output stalls the compare loop; in_ch.ready is high only between items.
// Reset clears control state, counts and the sticky overflow flag; FIFO data is not cleared.
`timescale 1ns / 1ps
module sorted_row_set_merge_unit #(
	parameter int FIFO_DEPTH  = 16,
	parameter int OFFSET_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	srsm_in_if.sink     in_ch,
	srsm_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	logic                   mode_q;
	srsm_pkg::fifo_cmd_t    l_cmd, r_cmd;
	srsm_pkg::fifo_stat_t   l_stat, r_stat;
	logic [OFFSET_BITS-1:0] l_data, r_data;
	srsm_pkg::res_ctl_t     res;
	logic [OFFSET_BITS-1:0] res_offset;
	logic                   overflow;
	logic                   slot_free;

	logic                   out_vld_q;
	logic                   out_elem_q;
	logic [OFFSET_BITS-1:0] out_off_q;
	logic                   out_last_q;
	logic                   out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_we)
			mode_q <= cfg_wdata;
	end

	srsm_fifo #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH (OFFSET_BITS)
	) u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (l_cmd),
		.wr_data (in_ch.row_offset),
		.stat    (l_stat),
		.rd_data (l_data)
	);

	srsm_fifo #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH (OFFSET_BITS)
	) u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (r_cmd),
		.wr_data (in_ch.row_offset),
		.stat    (r_stat),
		.rd_data (r_data)
	);

	srsm_ctrl #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.side        (in_ch.side),
		.has_element (in_ch.has_element),
		.side_last   (in_ch.side_last),
		.merge_mode  (mode_q),
		.l_cmd       (l_cmd),
		.r_cmd       (r_cmd),
		.l_stat      (l_stat),
		.r_stat      (r_stat),
		.l_data      (l_data),
		.r_data      (r_data),
		.slot_free   (slot_free),
		.res         (res),
		.res_offset  (res_offset),
		.overflow    (overflow)
	);

	assign slot_free = !out_vld_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (res.put)
			out_vld_q <= 1'b1;
		else if (out_ch.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res.put) begin
			out_elem_q <= res.elem;
			out_off_q  <= res_offset;
			out_last_q <= res.last;
			out_err_q  <= overflow;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.out_valid      = out_elem_q;
	assign out_ch.out_offset     = out_off_q;
	assign out_ch.out_last       = out_last_q;
	assign out_ch.overflow_error = out_err_q;

endmodule
